[design/bhta_pkg.sv]
package bhta_pkg;

  localparam int BucketBitsDef = 12;
  localparam int WaysDef       = 4;

  localparam int KeyW     = 64;
  localparam int TagW     = 32;
  localparam int TagLsb   = 32;
  localparam int MoveW    = 32;
  localparam int ScoreW   = 16;
  localparam int DepthW   = 8;
  localparam int KindW    = 2;
  localparam int AgeW     = 16;
  localparam int EvalW    = 16;
  localparam int OccW     = 15;
  localparam int WayCodeW = 3;
  localparam int AgeShift = 9;
  localparam int RankW    = AgeW + AgeShift;

  localparam logic [OccW-1:0] OccMax = '1;

  localparam logic OpProbe = 1'b0;
  localparam logic OpStore = 1'b1;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [MoveW-1:0]  mv;
    logic [ScoreW-1:0] score;
    logic [DepthW-1:0] depth;
    logic [KindW-1:0]  kind;
    logic [AgeW-1:0]   age;
    logic [EvalW-1:0]  eval;
  } entry_t;

  // Outcome of the bucket compare, handed from the selector to the control.
  typedef struct packed {
    logic                hit;
    logic [WayCodeW-1:0] way;
    logic                empty;
    logic                tag_eq;
  } sel_t;

  function automatic logic [RankW-1:0] repl_rank(entry_t e);
    return (RankW'(e.age) << AgeShift) + RankW'(e.depth);
  endfunction

endpackage

[design/bhta_ram.sv]
module bhta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/bhta_bucket_sel.sv]
module bhta_bucket_sel #(
  parameter int WAYS = bhta_pkg::WaysDef
) (
  input  bhta_pkg::entry_t [WAYS-1:0] row_i,
  input  logic                        op_i,
  input  logic [bhta_pkg::TagW-1:0]   tag_i,
  output bhta_pkg::sel_t              sel_o
);
  import bhta_pkg::*;

  localparam int WayW = $clog2(WAYS);

  always_comb begin
    logic [RankW-1:0] best_rank;
    logic [WayW-1:0]  idx;
    sel_o     = '0;
    best_rank = repl_rank(row_i[0]);
    if (op_i == OpProbe) begin
      // Walk downward so the lowest matching way wins.
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (row_i[w].tag == tag_i && row_i[w].kind != '0) begin
          sel_o.hit = 1'b1;
          sel_o.way = WayCodeW'(w);
        end
      end
    end else begin
      sel_o.hit = 1'b1;
      // Victim by lowest rank; a strict compare keeps the earliest way on ties.
      for (int w = 1; w < WAYS; w++) begin
        if (repl_rank(row_i[w]) < best_rank) begin
          best_rank = repl_rank(row_i[w]);
          sel_o.way = WayCodeW'(w);
        end
      end
      // An empty or matching way overrides the victim; lowest such way first.
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (row_i[w].kind == '0 || row_i[w].tag == tag_i) begin
          sel_o.way = WayCodeW'(w);
        end
      end
    end
    idx          = sel_o.way[WayW-1:0];
    sel_o.empty  = (row_i[idx].kind == '0);
    sel_o.tag_eq = (row_i[idx].tag == tag_i);
  end

endmodule

[design/bucketed_hash_table_with_aging_unit.sv]
// Set-associative result table with age-based replacement. A transaction is
// accepted when start is high and busy is low; its result is registered onto the
// output ports after the way compare and marked by done_o, high for exactly one
// cycle, and the receiver cannot hold it off. Every transaction first reads the
// whole bucket into the read register of the single bucket-wide RAM, then compares
// the ways, writes the chosen way back on a store and registers the result; busy
// stays high during the compare. After reset the RAM is cleared one bucket per
// cycle, with busy high, over all 2**BUCKET_BITS buckets (4096 by default);
// search_age can be written through the APB port at any time the block is idle.
module bucketed_hash_table_with_aging_unit #(
  parameter int BUCKET_BITS = bhta_pkg::BucketBitsDef,
  parameter int WAYS        = bhta_pkg::WaysDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation_i,
  input  logic [bhta_pkg::KeyW-1:0]         position_key_i,
  input  logic [bhta_pkg::DepthW-1:0]       search_depth_i,
  input  logic signed [bhta_pkg::ScoreW-1:0] result_score_i,
  input  logic [bhta_pkg::KindW-1:0]        bound_kind_i,
  input  logic [bhta_pkg::MoveW-1:0]        best_move_i,
  input  logic signed [bhta_pkg::EvalW-1:0] static_eval_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic [bhta_pkg::WayCodeW-1:0]     way_used_o,
  output logic [bhta_pkg::DepthW-1:0]       out_depth_o,
  output logic signed [bhta_pkg::ScoreW-1:0] out_score_o,
  output logic [bhta_pkg::KindW-1:0]        out_kind_o,
  output logic [bhta_pkg::MoveW-1:0]        out_move_o,
  output logic signed [bhta_pkg::EvalW-1:0] out_eval_o,
  output logic [bhta_pkg::AgeW-1:0]         out_age_o,
  output logic [bhta_pkg::OccW-1:0]         filled_count_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bhta_pkg::*;

  localparam int Buckets = 1 << BUCKET_BITS;
  localparam int WayW    = $clog2(WAYS);
  localparam int RowW    = WAYS * $bits(entry_t);

  localparam logic RegSearchAge = 1'b0;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StEval  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [BUCKET_BITS-1:0] clr_cnt_q;
  logic [AgeW-1:0] search_age_q;
  logic [OccW-1:0] occ_q;
  logic done_q;

  logic                   op_q;
  logic [TagW-1:0]        tag_q;
  logic [BUCKET_BITS-1:0] bucket_q;
  logic [DepthW-1:0]      depth_q;
  logic [ScoreW-1:0]      score_q;
  logic [KindW-1:0]       kind_q;
  logic [MoveW-1:0]       move_q;
  logic [EvalW-1:0]       eval_q;

  logic accept;
  logic cfg_we;
  logic ram_we;
  logic [BUCKET_BITS-1:0] ram_waddr;
  logic [RowW-1:0] ram_wdata;
  logic [RowW-1:0] ram_rdata;
  entry_t [WAYS-1:0] row_rd;
  entry_t [WAYS-1:0] row_wr;
  entry_t new_entry;
  entry_t res_entry_d, res_entry_q;
  logic [WayW-1:0] way_idx;
  sel_t sel;
  logic res_hit_q;
  logic [WayCodeW-1:0] res_way_q;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegSearchAge);
  assign prdata = (paddr[2] == RegSearchAge) ? {{(32 - AgeW){1'b0}}, search_age_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_age_q <= '0;
    end else if (cfg_we) begin
      search_age_q <= pwdata[AgeW-1:0];
    end
  end

  // Bucket memory: one row holds every way of a bucket.
  bhta_ram #(
    .Width(RowW),
    .Depth(Buckets)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(position_key_i[BUCKET_BITS-1:0]),
    .rdata_o(ram_rdata)
  );

  assign row_rd = ram_rdata;

  bhta_bucket_sel #(
    .WAYS(WAYS)
  ) u_sel (
    .row_i(row_rd),
    .op_i (op_q),
    .tag_i(tag_q),
    .sel_o(sel)
  );

  assign way_idx = sel.way[WayW-1:0];

  always_comb begin
    new_entry       = '0;
    new_entry.tag   = tag_q;
    // A matching tag keeps its old move when no new move is given.
    new_entry.mv    = (sel.tag_eq && move_q == '0) ? row_rd[way_idx].mv : move_q;
    new_entry.score = score_q;
    new_entry.depth = depth_q;
    new_entry.kind  = kind_q;
    new_entry.age   = search_age_q;
    new_entry.eval  = eval_q;
    row_wr          = row_rd;
    row_wr[way_idx] = new_entry;
  end

  always_comb begin
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      StEval: begin
        ram_we    = (op_q == OpStore);
        ram_waddr = bucket_q;
        ram_wdata = row_wr;
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = bucket_q;
        ram_wdata = row_wr;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_cnt_q == BUCKET_BITS'(Buckets - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StEval;
        end
      end
      StEval:  state_d = StIdle;
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
      occ_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StEval);
      if (state_q == StClear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == StEval && op_q == OpStore && sel.empty && occ_q != OccMax) begin
        occ_q <= occ_q + 1'b1;
      end
    end
  end

  // Transaction payload is captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      tag_q    <= position_key_i[TagLsb +: TagW];
      bucket_q <= position_key_i[BUCKET_BITS-1:0];
      depth_q  <= search_depth_i;
      score_q  <= $unsigned(result_score_i);
      kind_q   <= bound_kind_i;
      move_q   <= best_move_i;
      eval_q   <= $unsigned(static_eval_i);
    end
  end

  always_comb begin
    if (op_q == OpStore) begin
      res_entry_d = new_entry;
    end else if (sel.hit) begin
      res_entry_d = row_rd[way_idx];
    end else begin
      res_entry_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StEval) begin
      res_entry_q <= res_entry_d;
      res_hit_q   <= sel.hit;
      res_way_q   <= sel.hit ? sel.way : '0;
    end
  end

  assign done_o         = done_q;
  assign hit_o          = res_hit_q;
  assign way_used_o     = res_way_q;
  assign out_depth_o    = res_entry_q.depth;
  assign out_score_o    = $signed(res_entry_q.score);
  assign out_kind_o     = res_entry_q.kind;
  assign out_move_o     = res_entry_q.mv;
  assign out_eval_o     = $signed(res_entry_q.eval);
  assign out_age_o      = res_entry_q.age;
  assign filled_count_o = occ_q;

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted transaction produced no result two cycles later");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !ram_we)
    else $error("bucket memory written while idle");

  a_occ_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StClear |-> occ_q >= $past(occ_q))
    else $error("fill count decreased");

  a_miss_reports_way_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> way_used_o == '0 && out_kind_o == '0)
    else $error("probe miss carries entry data");

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bhta_pkg::*;

  localparam int BucketBits = BucketBitsDef;
  localparam int Ways       = WaysDef;
  localparam int Slots      = (1 << BucketBits) * Ways;
  localparam int IdlePct    = 23;
  localparam logic [2:0] AddrSearchAge = 3'd0;

  typedef struct packed {
    logic              op;
    logic [KeyW-1:0]   key;
    logic [DepthW-1:0] depth;
    logic [ScoreW-1:0] score;
    logic [KindW-1:0]  kind;
    logic [MoveW-1:0]  mv;
    logic [EvalW-1:0]  ev;
  } table_req_t;

  typedef struct packed {
    logic                hit;
    logic [WayCodeW-1:0] way;
    logic [DepthW-1:0]   depth;
    logic [ScoreW-1:0]   score;
    logic [KindW-1:0]    kind;
    logic [MoveW-1:0]    mv;
    logic [EvalW-1:0]    ev;
    logic [AgeW-1:0]     age;
    logic [OccW-1:0]     filled;
  } table_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = OpProbe;
  logic [KeyW-1:0] position_key_i = '0;
  logic [DepthW-1:0] search_depth_i = '0;
  logic signed [ScoreW-1:0] result_score_i = '0;
  logic [KindW-1:0] bound_kind_i = '0;
  logic [MoveW-1:0] best_move_i = '0;
  logic signed [EvalW-1:0] static_eval_i = '0;
  logic done_o;
  logic hit_o;
  logic [WayCodeW-1:0] way_used_o;
  logic [DepthW-1:0] out_depth_o;
  logic signed [ScoreW-1:0] out_score_o;
  logic [KindW-1:0] out_kind_o;
  logic [MoveW-1:0] out_move_o;
  logic signed [EvalW-1:0] out_eval_o;
  logic [AgeW-1:0] out_age_o;
  logic [OccW-1:0] filled_count_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #10 clk_i = ~clk_i;

  bucketed_hash_table_with_aging_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .position_key_i (position_key_i),
    .search_depth_i (search_depth_i),
    .result_score_i (result_score_i),
    .bound_kind_i   (bound_kind_i),
    .best_move_i    (best_move_i),
    .static_eval_i  (static_eval_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .way_used_o     (way_used_o),
    .out_depth_o    (out_depth_o),
    .out_score_o    (out_score_o),
    .out_kind_o     (out_kind_o),
    .out_move_o     (out_move_o),
    .out_eval_o     (out_eval_o),
    .out_age_o      (out_age_o),
    .filled_count_o (filled_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Shadow copy of the table, the occupancy count and the age register.
  entry_t slots [Slots];
  logic [OccW-1:0] occupancy_model;
  logic [AgeW-1:0] age_model;

  table_rsp_t pending_results [$];
  int mismatches;
  bit gaps_on;
  logic [TagW-1:0] tag_pool [8];
  logic [BucketBits-1:0] bucket_pool [6];

  function automatic table_rsp_t apply_request(table_req_t rq);
    int unsigned base;
    int unsigned way;
    int unsigned best;
    logic [TagW-1:0] tag;
    logic [RankW-1:0] rank;
    logic [RankW-1:0] best_rank;
    logic found;
    entry_t e;
    table_rsp_t rsp;
    tag = rq.key[KeyW-1:TagLsb];
    base = 32'(rq.key[BucketBits-1:0]);
    base = base * Ways;
    way = 0;
    found = 1'b0;
    rsp = '0;
    if (rq.op == OpProbe) begin
      for (int w = 0; w < Ways; w++) begin
        if (!found && slots[base+w].kind != '0 && slots[base+w].tag == tag) begin
          found = 1'b1;
          way = w;
        end
      end
    end else begin
      // Way 0 or the first later way that is empty or already holds the tag;
      // failing that, the way with the lowest age/depth rank.
      best = 0;
      best_rank = '1;
      for (int w = 0; w < Ways; w++) begin
        e = slots[base+w];
        rank = repl_rank(e);
        if (!found) begin
          if (e.kind == '0 || e.tag == tag) begin
            found = 1'b1;
            way = w;
          end else if (w == 0 || rank < best_rank) begin
            best_rank = rank;
            best = w;
          end
        end
      end
      if (!found) way = best;
      found = 1'b1;
      e = slots[base+way];
      if (e.kind == '0 && occupancy_model != OccMax) occupancy_model++;
      if (e.tag != tag || rq.mv != '0) e.mv = rq.mv;
      e.tag = tag;
      e.score = rq.score;
      e.depth = rq.depth;
      e.kind = rq.kind;
      e.age = age_model;
      e.eval = rq.ev;
      slots[base+way] = e;
    end
    if (found) begin
      e = slots[base+way];
      rsp.hit = 1'b1;
      rsp.way = WayCodeW'(way);
      rsp.depth = e.depth;
      rsp.score = e.score;
      rsp.kind = e.kind;
      rsp.mv = e.mv;
      rsp.ev = e.eval;
      rsp.age = e.age;
    end
    rsp.filled = occupancy_model;
    return rsp;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic compare_result(table_rsp_t want, table_rsp_t got);
    if (got.hit !== want.hit) note_mismatch("hit", 64'(want.hit), 64'(got.hit));
    if (got.way !== want.way) note_mismatch("way_used", 64'(want.way), 64'(got.way));
    if (got.depth !== want.depth) begin
      note_mismatch("out_depth", 64'(want.depth), 64'(got.depth));
    end
    if (got.score !== want.score) begin
      note_mismatch("out_score", 64'(want.score), 64'(got.score));
    end
    if (got.kind !== want.kind) note_mismatch("out_kind", 64'(want.kind), 64'(got.kind));
    if (got.mv !== want.mv) note_mismatch("out_move", 64'(want.mv), 64'(got.mv));
    if (got.ev !== want.ev) note_mismatch("out_eval", 64'(want.ev), 64'(got.ev));
    if (got.age !== want.age) note_mismatch("out_age", 64'(want.age), 64'(got.age));
    if (got.filled !== want.filled) begin
      note_mismatch("filled_count", 64'(want.filled), 64'(got.filled));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    table_rsp_t got;
    if (rst_ni && done_o) begin
      got = {hit_o, way_used_o, out_depth_o, out_score_o, out_kind_o, out_move_o,
             out_eval_o, out_age_o, filled_count_o};
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, 64'(got.way));
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
    end
  end

  // Presents one transaction and records its expected result once accepted.
  task automatic send_request(table_req_t rq);
    if (gaps_on && $urandom_range(99) < IdlePct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= rq.op;
    position_key_i <= rq.key;
    search_depth_i <= rq.depth;
    result_score_i <= rq.score;
    bound_kind_i   <= rq.kind;
    best_move_i    <= rq.mv;
    static_eval_i  <= rq.ev;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(apply_request(rq));
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_search_age(logic [AgeW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrSearchAge;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    age_model = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(value)) note_mismatch("search_age readback", 32'(value), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic table_req_t make_req(logic op, logic [KeyW-1:0] key,
                                          logic [DepthW-1:0] depth,
                                          logic [ScoreW-1:0] score,
                                          logic [KindW-1:0] kind,
                                          logic [MoveW-1:0] mv,
                                          logic [EvalW-1:0] ev);
    return '{op: op, key: key, depth: depth, score: score, kind: kind, mv: mv, ev: ev};
  endfunction

  function automatic logic [KeyW-1:0] key_in_bucket5(logic [TagW-1:0] tag);
    return {tag, 32'h5};
  endfunction

  task automatic test_probe_and_store_basics();
    send_request(make_req(OpProbe, '0, '0, '0, '0, '0, '0));
    send_request(make_req(OpProbe, '1, '0, '0, '0, '0, '0));
    send_request(make_req(OpStore, '1, 8'hff, 16'h8000, 2'd3, '1, 16'h7fff));
    send_request(make_req(OpProbe, '1, '0, '0, '0, '0, '0));
    // A store of an empty kind still counts as filling a way.
    send_request(make_req(OpStore, '0, 8'h00, 16'h7fff, 2'd0, '0, 16'h8000));
    // The tag is present but the kind is empty, so the probe misses.
    send_request(make_req(OpProbe, '0, '0, '0, '0, '0, '0));
    send_request(make_req(OpStore, '0, 8'd1, 16'd1, 2'd1, 32'h1234_5678, 16'hffff));
    // Same tag with a zero move keeps the stored move.
    send_request(make_req(OpStore, '0, 8'd2, 16'd2, 2'd2, '0, 16'd2));
    send_request(make_req(OpProbe, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_way_selection();
    send_request(make_req(OpStore, key_in_bucket5(1), 8'd10, 16'd11, 2'd1, 32'd101, 16'd1));
    send_request(make_req(OpStore, key_in_bucket5(2), 8'd3, 16'd12, 2'd2, 32'd102, 16'd2));
    send_request(make_req(OpStore, key_in_bucket5(3), 8'd7, 16'd13, 2'd3, 32'd103, 16'd3));
    send_request(make_req(OpStore, key_in_bucket5(4), 8'd3, 16'd14, 2'd1, 32'd104, 16'd4));
    send_request(make_req(OpProbe, key_in_bucket5(3), '0, '0, '0, '0, '0));
    // Full bucket, ways 1 and 3 tie on rank: the earlier one is replaced.
    send_request(make_req(OpStore, key_in_bucket5(9), 8'd20, 16'd15, 2'd2, 32'd109, 16'd5));
    send_request(make_req(OpProbe, key_in_bucket5(2), '0, '0, '0, '0, '0));
    wait_until_drained();
    write_search_age('1);
    send_request(make_req(OpStore, key_in_bucket5(10), 8'd0, 16'd16, 2'd3, 32'd110, 16'd6));
    send_request(make_req(OpStore, key_in_bucket5(11), 8'd255, 16'd17, 2'd1, 32'd111, 16'd7));
    // A matching tag in way 0 is rewritten in place and keeps its move.
    send_request(make_req(OpStore, key_in_bucket5(1), 8'd0, 16'd18, 2'd3, '0, 16'd8));
    send_request(make_req(OpStore, key_in_bucket5(10), 8'd1, 16'd19, 2'd0, '0, 16'd9));
    // Way 3 is empty again, so a new tag lands there and occupancy rises.
    send_request(make_req(OpStore, key_in_bucket5(12), 8'd2, 16'd20, 2'd2, 32'd112, 16'd10));
    send_request(make_req(OpProbe, key_in_bucket5(12), '0, '0, '0, '0, '0));
  endtask

  function automatic table_req_t hot_request();
    table_req_t rq;
    rq.op = ($urandom_range(99) < 70) ? OpStore : OpProbe;
    rq.key[KeyW-1:TagLsb] = tag_pool[$urandom_range(7)];
    rq.key[TagLsb-1:0] = $urandom();
    rq.key[BucketBits-1:0] = bucket_pool[$urandom_range(5)];
    rq.depth = DepthW'($urandom_range(255));
    rq.score = ScoreW'($urandom());
    rq.kind = ($urandom_range(7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    rq.mv = ($urandom_range(3) == 0) ? '0 : $urandom();
    rq.ev = EvalW'($urandom());
    return rq;
  endfunction

  task automatic test_hot_buckets();
    logic [AgeW-1:0] ages [4];
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = $urandom();
    bucket_pool[0] = '0;
    bucket_pool[1] = BucketBits'(1);
    bucket_pool[2] = BucketBits'(5);
    bucket_pool[3] = BucketBits'(1 << (BucketBits - 1));
    bucket_pool[4] = '1;
    bucket_pool[5] = BucketBits'((1 << BucketBits) - 2);
    ages[0] = AgeW'(1);
    ages[1] = AgeW'($urandom_range(65535));
    ages[2] = '1;
    ages[3] = '0;
    for (int phase = 0; phase < 4; phase++) begin
      wait_until_drained();
      write_search_age(ages[phase]);
      // One phase runs back to back with no gaps at all.
      gaps_on = (phase != 1);
      for (int n = 0; n < 140; n++) send_request(hot_request());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_scattered_keys();
    table_req_t rq;
    wait_until_drained();
    write_search_age(AgeW'($urandom_range(65535)));
    for (int n = 0; n < 90; n++) begin
      rq.op = 1'($urandom_range(1));
      rq.key = {$urandom(), $urandom()};
      rq.depth = DepthW'($urandom());
      rq.score = ScoreW'($urandom());
      rq.kind = KindW'($urandom());
      rq.mv = $urandom();
      rq.ev = EvalW'($urandom());
      send_request(rq);
    end
  endtask

  initial begin
    foreach (slots[i]) slots[i] = '0;
    occupancy_model = '0;
    age_model = '0;
    mismatches = 0;
    gaps_on = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The table clears itself after reset with busy held high.
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    write_search_age('0);
    test_probe_and_store_basics();
    test_way_selection();
    test_hot_buckets();
    test_scattered_keys();
    wait_until_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bucketed_hash_table_with_aging_unit regression: pass");
    end else begin
      $display("bucketed_hash_table_with_aging_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("bucketed_hash_table_with_aging_unit regression: fail");
    $finish;
  end

endmodule
